// File: sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg - shared definitions for the midpoint circle rasterizer
// Widths, operation codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 9;
    localparam int PIX_BITS    = COORD_BITS + 2;
    localparam int DEC_BITS    = RADIUS_BITS + 3;

    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

    localparam int PIX_PER_JOB = 16;
    localparam int IDX_BITS    = $clog2(PIX_PER_JOB);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // one iteration: center, point before and after the advance, finish flag
    typedef struct packed {
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] x0;
        logic [RADIUS_BITS-1:0] y0;
        logic [RADIUS_BITS-1:0] x1;
        logic [RADIUS_BITS-1:0] y1;
        logic                   done;
    } t_job;

endpackage

// File: sv/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front - octant walker
// Takes start and step items, keeps the midpoint state and issues one job
// per step item that draws.
// ----------------------------------------------------------------------------
module mcr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_operation,
    input  logic [mcr_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic [mcr_pkg::RADIUS_BITS-1:0] i_radius,
    output logic                            o_push,
    output mcr_pkg::t_job                   o_job
);

    localparam int RB = mcr_pkg::RADIUS_BITS;
    localparam int DB = mcr_pkg::DEC_BITS;

    logic [mcr_pkg::COORD_BITS-1:0] r_cx, r_cy;
    logic [RB-1:0]                  r_x, r_y;
    logic signed [DB-1:0]           r_dec;
    logic                           r_busy;

    logic [RB-1:0]        n_x, n_y;
    logic signed [DB-1:0] n_dec;
    logic signed [RB:0]   w_diff;
    logic signed [DB-1:0] w_inc;
    logic                 w_step;

    assign w_step = i_accept && (i_operation == mcr_pkg::OP_STEP) && r_busy;

    always_comb begin
        n_x    = r_x + RB'(1);
        w_diff = $signed({1'b0, n_x}) - $signed({1'b0, r_y - RB'(1)});
        if (r_dec[DB-1]) begin
            n_y   = r_y;
            w_inc = $signed(DB'({n_x, 1'b1}));
        end else begin
            n_y   = r_y - RB'(1);
            // 2*(x-y)+1, sign-extended
            w_inc = $signed({{(DB-RB-2){w_diff[RB]}}, w_diff, 1'b1});
        end
        n_dec = r_dec + w_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_dec  <= '0;
            r_busy <= 1'b0;
        end else if (i_accept && (i_operation == mcr_pkg::OP_START)) begin
            r_cx   <= i_center_x;
            r_cy   <= i_center_y;
            r_x    <= '0;
            r_y    <= i_radius;
            r_dec  <= DB'(1) - $signed(DB'(i_radius));
            r_busy <= (i_radius != '0);
        end else if (w_step) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_dec  <= n_dec;
            r_busy <= (n_x < n_y);
        end
    end

    assign o_push    = w_step;
    assign o_job.cx  = r_cx;
    assign o_job.cy  = r_cy;
    assign o_job.x0  = r_x;
    assign o_job.y0  = r_y;
    assign o_job.x1  = n_x;
    assign o_job.y1  = n_y;
    assign o_job.done = !(n_x < n_y);

endmodule

// File: sv/mcr_fifo.sv
// ----------------------------------------------------------------------------
// mcr_fifo - job queue
// Short queue that decouples the octant walker from the pixel emitter.
// ----------------------------------------------------------------------------
module mcr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcr_pkg::t_job i_data,
    input  logic          i_pop,
    output mcr_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);

    mcr_pkg::t_job r_mem [mcr_pkg::QDEPTH];

    logic [mcr_pkg::QPTR_BITS-1:0] r_wr, r_rd;
    logic [mcr_pkg::QCNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == mcr_pkg::QCNT_BITS'(mcr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1)) ?
                        '0 : r_wr + mcr_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1)) ?
                        '0 : r_rd + mcr_pkg::QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + mcr_pkg::QCNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - mcr_pkg::QCNT_BITS'(1);
            end
        end
    end

endmodule

// File: sv/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back - pixel emitter
// Expands one job into sixteen symmetric pixels, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module mcr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcr_pkg::t_job                i_job,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [mcr_pkg::PIX_BITS-1:0] o_pixel_x,
    output logic [mcr_pkg::PIX_BITS-1:0] o_pixel_y,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);

    localparam int PB = mcr_pkg::PIX_BITS;
    localparam int IB = mcr_pkg::IDX_BITS;

    mcr_pkg::t_job r_job;
    logic          r_job_valid;
    logic [IB-1:0] r_idx;

    logic          r_valid;
    logic [PB-1:0] r_px, r_py;
    logic          r_last, r_done;

    logic                           w_load, w_last;
    logic [mcr_pkg::RADIUS_BITS-1:0] w_px, w_py, w_a, w_b;
    logic [PB-1:0]                  w_cx, w_cy, n_px, n_py;

    assign w_load = r_job_valid && (!r_valid || !i_stall);
    assign w_last = (r_idx == IB'(mcr_pkg::PIX_PER_JOB - 1));
    assign o_pop  = !i_empty && (!r_job_valid || (w_load && w_last));

    always_comb begin
        // upper half of the sixteen uses the advanced point
        w_px = r_idx[3] ? r_job.x1 : r_job.x0;
        w_py = r_idx[3] ? r_job.y1 : r_job.y0;
        w_a  = r_idx[2] ? w_py : w_px;
        w_b  = r_idx[2] ? w_px : w_py;
        w_cx = PB'(r_job.cx);
        w_cy = PB'(r_job.cy);
        n_px = r_idx[0] ? (w_cx - PB'(w_a)) : (w_cx + PB'(w_a));
        n_py = r_idx[1] ? (w_cy - PB'(w_b)) : (w_cy + PB'(w_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (o_pop) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (w_load && w_last) begin
            r_job_valid <= 1'b0;
        end else if (w_load) begin
            r_idx <= r_idx + IB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_last <= w_last;
            r_done <= w_last && r_job.done;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

endmodule

// File: sv/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit - midpoint circle rasterizer, top level
// Front walker, two-entry job queue and sixteen-pixel emitter.
// ----------------------------------------------------------------------------
// A start item (operation 0) loads center and radius and yields no pixel;
// a zero radius leaves the block idle. Each step item (operation 1)
// on a circle in progress yields sixteen pixels, the eight symmetric points
// before and after one midpoint iteration, with last_of_step on the sixteenth
// and circle_done there too once x is no longer below y. Steps while idle
// yield nothing. The input side takes one item per cycle while the two-entry
// job queue has room; the pixel emitter delivers one pixel per cycle while
// the output is not stalled, so each drawing step occupies the output for
// sixteen pixels. A step item's first pixel passes through the job queue,
// the emitter's job register and its output pixel register.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic [mcr_pkg::COORD_BITS-1:0]  i_center_x,
    input  logic [mcr_pkg::COORD_BITS-1:0]  i_center_y,
    input  logic [mcr_pkg::RADIUS_BITS-1:0] i_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [mcr_pkg::PIX_BITS-1:0] o_pixel_x,
    output logic signed [mcr_pkg::PIX_BITS-1:0] o_pixel_y,
    output logic                            o_last_of_step,
    output logic                            o_circle_done
);

    logic          w_accept, w_push, w_pop, w_full, w_empty;
    mcr_pkg::t_job w_job_in, w_job_out;
    logic [mcr_pkg::PIX_BITS-1:0] w_px, w_py;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    mcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_operation),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    mcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_job_out),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_pixel_x      (w_px),
        .o_pixel_y      (w_py),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    assign o_pixel_x = $signed(w_px);
    assign o_pixel_y = $signed(w_py);

endmodule

// File: sv/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker - port-level checks for the circle rasterizer
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module mcr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [mcr_pkg::PIX_BITS-1:0]    o_pixel_x,
    input logic [mcr_pkg::PIX_BITS-1:0]    o_pixel_y,
    input logic                            o_last_of_step,
    input logic                            o_circle_done
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_x) && $stable(o_pixel_y))
        else $error("stalled pixel changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_circle_done |-> o_last_of_step)
        else $error("circle_done without last_of_step");

    // within an iteration the sixteen pixels come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_step |=> o_out_valid)
        else $error("gap inside an iteration");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_last_of_step (o_last_of_step),
    .o_circle_done  (o_circle_done)
);
